[rtl/core/crsf_pkg.sv]
// shared types, constants and the crc-8 byte update for the telemetry frame builder
// no dependencies; imported by the front end, queue, back end and top level
`default_nettype none

package crsf_pkg;

  // record kinds
  localparam logic KIND_GPS      = 1'b0;
  localparam logic KIND_ATTITUDE = 1'b1;

  // configuration register indexes
  localparam int unsigned    CFG_IDX_W          = 2;
  localparam logic [1:0]     REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0]     REG_CRC_POLYNOMIAL = 2'd1;
  localparam logic [7:0]     DEVICE_ADDRESS_RST = 8'd200;
  localparam logic [7:0]     CRC_POLYNOMIAL_RST = 8'hD5;

  // frame layout
  localparam logic [7:0]  TYPE_GPS      = 8'h02;
  localparam logic [7:0]  TYPE_ATTITUDE = 8'h1E;
  localparam logic [7:0]  LEN_GPS       = 8'd17;
  localparam logic [7:0]  LEN_ATTITUDE  = 8'd8;
  localparam logic [15:0] ALTITUDE_OFFSET = 16'd1000;

  localparam int unsigned PAYLOAD_W  = 120;
  localparam int unsigned BYTE_IDX_W = 5;
  localparam logic [BYTE_IDX_W-1:0] IDX_ADDR         = 5'd0;
  localparam logic [BYTE_IDX_W-1:0] IDX_LEN          = 5'd1;
  localparam logic [BYTE_IDX_W-1:0] IDX_TYPE         = 5'd2;
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX_GPS     = 5'd18;
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX_ATTITUDE = 5'd9;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic                 kind;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] crc_polynomial;
  } cfg_t;

  // eight msb-first shift steps of the crc, data already folded into acc
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] poly);
    logic [7:0] r;
    r = acc;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/crsf_front.sv]
// front end: takes one record, packs its payload bytes big-endian into a queue entry
// depends on crsf_pkg
`default_nettype none

module crsf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [31:0]          latitude_fixed_i,
  input  wire logic [31:0]          longitude_fixed_i,
  input  wire logic [15:0]          ground_speed_i,
  input  wire logic [15:0]          heading_word_i,
  input  wire logic [15:0]          altitude_metres_i,
  input  wire logic [7:0]           satellite_count_i,
  input  wire logic [15:0]          pitch_fixed_i,
  input  wire logic [15:0]          roll_fixed_i,
  input  wire logic [15:0]          yaw_fixed_i,
  output logic                      push_valid_o,
  output crsf_pkg::entry_t          push_entry_o,
  input  wire logic                 push_ready_i
);
  import crsf_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  entry_t packed_entry;
  logic   load;
  logic [15:0] altitude_sent;

  assign altitude_sent = altitude_metres_i + ALTITUDE_OFFSET;

  always_comb begin
    packed_entry.kind = kind_i;
    if (kind_i == KIND_GPS) begin
      packed_entry.payload = {latitude_fixed_i, longitude_fixed_i, ground_speed_i,
                              heading_word_i, altitude_sent, satellite_count_i};
    end else begin
      // attitude bytes sit at the top so the back end shifts them out first
      packed_entry.payload = {pitch_fixed_i, roll_fixed_i, yaw_fixed_i, 72'd0};
    end
  end

  assign in_stall_o   = valid_q && !push_ready_i;
  assign load         = in_valid_i && !in_stall_o;
  assign push_valid_o = valid_q;
  assign push_entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (load) begin
      valid_d = 1'b1;
      entry_d = packed_entry;
    end else if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

[rtl/core/crsf_queue.sv]
// short fifo of packed records between the front and back ends
// depends on crsf_pkg
`default_nettype none

module crsf_queue #(
  parameter int unsigned Depth = crsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  input  crsf_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output crsf_pkg::entry_t pop_entry_o,
  input  wire logic        pop_i
);
  import crsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/crsf_back.sv]
// back end: serialises one queued record into frame beats and folds in the crc
// depends on crsf_pkg
`default_nettype none

module crsf_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  crsf_pkg::cfg_t   cfg_i,
  input  wire logic        pop_valid_i,
  input  crsf_pkg::entry_t pop_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o
);
  import crsf_pkg::*;

  logic                  busy_q, busy_d;
  logic [BYTE_IDX_W-1:0] idx_q, idx_d;
  logic                  kind_q, kind_d;
  logic [PAYLOAD_W-1:0]  shift_q, shift_d;
  logic [7:0]            crc_q, crc_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            frame_byte_q, frame_byte_d;
  logic                  last_byte_q, last_byte_d;

  logic                  advance, emit, is_last;
  logic [BYTE_IDX_W-1:0] last_idx;
  logic [7:0]            beat_byte, crc_next;

  assign advance  = !out_valid_q || !out_stall_i;
  assign emit     = advance && busy_q;
  assign last_idx = (kind_q == KIND_GPS) ? LAST_IDX_GPS : LAST_IDX_ATTITUDE;
  assign is_last  = busy_q && (idx_q == last_idx);
  // next record is taken while the crc beat goes out
  assign pop_o    = advance && (!busy_q || is_last) && pop_valid_i;

  always_comb begin
    case (idx_q)
      IDX_ADDR: beat_byte = cfg_i.device_address;
      IDX_LEN:  beat_byte = (kind_q == KIND_GPS) ? LEN_GPS : LEN_ATTITUDE;
      IDX_TYPE: beat_byte = (kind_q == KIND_GPS) ? TYPE_GPS : TYPE_ATTITUDE;
      default:  beat_byte = is_last ? crc_q : shift_q[PAYLOAD_W-1 -: 8];
    endcase
  end

  assign crc_next = crc8_byte(crc_q ^ beat_byte, cfg_i.crc_polynomial);

  always_comb begin
    busy_d       = busy_q;
    idx_d        = idx_q;
    kind_d       = kind_q;
    shift_d      = shift_q;
    crc_d        = crc_q;
    out_valid_d  = out_valid_q;
    frame_byte_d = frame_byte_q;
    last_byte_d  = last_byte_q;

    if (advance) begin
      out_valid_d  = busy_q;
      frame_byte_d = beat_byte;
      last_byte_d  = is_last;
    end

    if (pop_o) begin
      busy_d  = 1'b1;
      idx_d   = IDX_ADDR;
      kind_d  = pop_entry_i.kind;
      shift_d = pop_entry_i.payload;
      crc_d   = '0;
    end else if (emit && is_last) begin
      busy_d = 1'b0;
    end else if (emit) begin
      idx_d = idx_q + 1'b1;
      if (idx_q > IDX_TYPE) begin
        shift_d = {shift_q[PAYLOAD_W-9:0], 8'd0};
      end
      if (idx_q >= IDX_TYPE) begin
        crc_d = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      kind_q      <= KIND_GPS;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q      <= shift_d;
    crc_q        <= crc_d;
    frame_byte_q <= frame_byte_d;
    last_byte_q  <= last_byte_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign last_byte_o  = last_byte_q;

endmodule

`default_nettype wire

[rtl/core/crsf_telemetry_frame_builder.sv]
// top level of the telemetry frame builder: configuration registers, front end, queue, back end
// depends on crsf_pkg, crsf_front, crsf_queue and crsf_back
`default_nettype none

// turns each telemetry record into one serial-link frame, one byte per output beat:
// device address, length, type, big-endian payload, then a crc-8 (msb first, init 0)
// over type and payload with the configured polynomial. a gps record (kind 0) gives
// 19 beats, an attitude record (kind 1) gives 10; last_byte_o marks the crc beat.
// the back end sends one beat per cycle from its output register while the output is
// not stalled; that beat rate is what limits throughput. the first beat of a frame
// passes through the input register, the queue and the load into the serialiser;
// the next record is loaded in the cycle that the crc beat goes out, so frames
// follow each other with no gap. the front end keeps taking records while the back
// end is busy until the queue (QueueDepth entries) and the input register are full.
// configuration writes are always taken (cfg_ready_o tied high) and must only be made
// while no frame is in flight; an index beyond the two registers is ignored.
module crsf_telemetry_frame_builder #(
  parameter int unsigned QueueDepth = crsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [crsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i,
  // record input
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           kind_i,
  input  wire logic [31:0]                    latitude_fixed_i,
  input  wire logic [31:0]                    longitude_fixed_i,
  input  wire logic [15:0]                    ground_speed_i,
  input  wire logic [15:0]                    heading_word_i,
  input  wire logic [15:0]                    altitude_metres_i,
  input  wire logic [7:0]                     satellite_count_i,
  input  wire logic [15:0]                    pitch_fixed_i,
  input  wire logic [15:0]                    roll_fixed_i,
  input  wire logic [15:0]                    yaw_fixed_i,
  // frame byte output
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          frame_byte_o,
  output logic                                last_byte_o
);
  import crsf_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   cfg_write;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop;
  entry_t pop_entry;

  // configuration registers, written in one beat each
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (cfg_index_i)
        REG_DEVICE_ADDRESS: cfg_d.device_address = cfg_data_i;
        REG_CRC_POLYNOMIAL: cfg_d.crc_polynomial = cfg_data_i;
        default:            cfg_d = cfg_q;   // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= DEVICE_ADDRESS_RST;
      cfg_q.crc_polynomial <= CRC_POLYNOMIAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: registers the record and packs its payload bytes
  crsf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .latitude_fixed_i  (latitude_fixed_i),
    .longitude_fixed_i (longitude_fixed_i),
    .ground_speed_i    (ground_speed_i),
    .heading_word_i    (heading_word_i),
    .altitude_metres_i (altitude_metres_i),
    .satellite_count_i (satellite_count_i),
    .pitch_fixed_i     (pitch_fixed_i),
    .roll_fixed_i      (roll_fixed_i),
    .yaw_fixed_i       (yaw_fixed_i),
    .push_valid_o      (push_valid),
    .push_entry_o      (push_entry),
    .push_ready_i      (push_ready)
  );

  // decoupling queue so each side can stall on its own
  crsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  // back end: one frame beat per cycle while the output is not stalled, with the running crc
  crsf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_entry_i  (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

`default_nettype wire

[rtl/core/crsf_chk.sv]
// port-level checker for the telemetry frame builder, bound to the top level
// depends only on the top level's port list
`default_nettype none

module crsf_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic cfg_valid_i,
  input wire logic cfg_ready_o,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [7:0] frame_byte_o,
  input wire logic last_byte_o
);

  // a stalled output beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) && $stable(last_byte_o))
    else $error("output beat changed while stalled");

  // the beat after a crc beat opens a new frame, never another crc beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_byte_o |=> !(out_valid_o && last_byte_o))
    else $error("two frame ends in a row");

  // nothing is offered or held back while in reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("handshake active during reset");

  // configuration channel never back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

  // input stall only follows a taken record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i) || $past(in_stall_o))
    else $error("input stalled with no record taken");

endmodule

bind crsf_telemetry_frame_builder crsf_chk u_crsf_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

`default_nettype wire

[dv/tb_top.sv]
// self-checking bench for crsf_telemetry_frame_builder: random and directed telemetry records
// in, serial-link frame bytes out, checked against a frame predictor kept inside the bench
// depends on crsf_pkg and the rtl top level only
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;

  // register indexes past the two real registers, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // frame layout as the link protocol defines it
  localparam logic [7:0]  GPS_FRAME_TYPE = 8'h02;
  localparam logic [7:0]  ATT_FRAME_TYPE = 8'h1E;
  localparam int          GPS_PAYLOAD_BYTES = 15;
  localparam int          ATT_PAYLOAD_BYTES = 6;
  localparam logic [15:0] ALT_BIAS = 16'd1000;

  localparam int HOLD_CYCLES        = 300;   // long receiver hold-off
  localparam int STALL_LIMIT_CYCLES = 3000;  // cycles with no beat at all before giving up
  localparam int TAIL_CYCLES        = 20;

  // one telemetry record as it sits on the input ports
  typedef struct packed {
    logic               kind;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [15:0]        speed;
    logic [15:0]        heading;
    logic [15:0]        altitude;
    logic [7:0]         satellites;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } record_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_data_i  = '0;

  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  record_t offered    = '0;

  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;

  // bench copy of the two registers, only changed while the block is idle
  logic [7:0] addr_shadow = DEVICE_ADDRESS_RST;
  logic [7:0] poly_shadow = CRC_POLYNOMIAL_RST;

  record_t     records_to_send[$];
  frame_beat_t frame_beats_due[$];
  int          mismatch_count = 0;

  // idling knobs, percent chance of starting a burst
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_requests = 0;

  crsf_telemetry_frame_builder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (offered.kind),
    .latitude_fixed_i  (offered.latitude),
    .longitude_fixed_i (offered.longitude),
    .ground_speed_i    (offered.speed),
    .heading_word_i    (offered.heading),
    .altitude_metres_i (offered.altitude),
    .satellite_count_i (offered.satellites),
    .pitch_fixed_i     (offered.pitch),
    .roll_fixed_i      (offered.roll),
    .yaw_fixed_i       (offered.yaw),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_byte_o      (frame_byte_o),
    .last_byte_o       (last_byte_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // appends one expected beat to the scoreboard
  function automatic void add_due_beat(input logic [7:0] data, input logic last);
    frame_beat_t b;
    b.data = data;
    b.last = last;
    frame_beats_due.insert(frame_beats_due.size(), b);
  endfunction

  // appends one record to the driver's pending list
  function automatic void queue_record(input record_t r);
    records_to_send.insert(records_to_send.size(), r);
  endfunction

  // frame predictor: lays out address, length, type and big-endian payload, then
  // runs the crc bit by bit over type and payload with the shadow polynomial
  function automatic void build_frame(input record_t r);
    logic [119:0] payload;
    logic [7:0]   body[$];
    logic [7:0]   crc;
    logic [7:0]   cur;
    logic [15:0]  alt_sent;
    logic         fb;
    int           n;
    alt_sent = r.altitude + ALT_BIAS;  // wraps at 16 bits, no saturation
    if (r.kind == KIND_GPS) begin
      n = GPS_PAYLOAD_BYTES;
      payload = {r.latitude, r.longitude, r.speed, r.heading, alt_sent, r.satellites};
      body.insert(body.size(), GPS_FRAME_TYPE);
    end else begin
      n = ATT_PAYLOAD_BYTES;
      payload = {72'd0, r.pitch, r.roll, r.yaw};
      body.insert(body.size(), ATT_FRAME_TYPE);
    end
    for (int k = 0; k < n; k++) begin
      body.insert(body.size(), payload[8*(n-1-k) +: 8]);
    end
    add_due_beat(addr_shadow, 1'b0);
    add_due_beat(8'(n + 2), 1'b0);
    crc = 8'h00;
    foreach (body[j]) begin
      cur = body[j];
      add_due_beat(cur, 1'b0);
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[7] ^ cur[i];
        crc = {crc[6:0], 1'b0};
        if (fb) begin
          crc = crc ^ poly_shadow;
        end
      end
    end
    add_due_beat(crc, 1'b1);
  endfunction

  // driver: holds a stalled beat, otherwise either idles a burst or offers the next record
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offered    <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        build_frame(offered);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (records_to_send.size() > 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left   <= $urandom_range(0, 11);
          in_valid_i <= 1'b0;
        end else if (records_to_send.size() > 0) begin
          offered    <= records_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each accepted beat with the oldest pending one and drives the stall
  int hold_left    = 0;
  int holds_served = 0;
  int stall_left   = 0;

  task automatic check_beat();
    frame_beat_t want;
    if (frame_beats_due.size() == 0) begin
      $error("frame_byte beat %02h with no frame pending", frame_byte_o);
      mismatch_count++;
    end else begin
      want = frame_beats_due.pop_front();
      if (frame_byte_o !== want.data) begin
        $error("frame_byte expected %02h actual %02h", want.data, frame_byte_o);
        mismatch_count++;
      end
      if (last_byte_o !== want.last) begin
        $error("last_byte expected %0b actual %0b", want.last, last_byte_o);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
      stall_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_beat();
      end
      if (holds_served != hold_requests) begin
        // long hold-off so the block backs up into its input
        holds_served <= hold_requests;
        hold_left    <= HOLD_CYCLES - 1;
        out_stall_i  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left  <= $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: counts cycles in which no beat moves on any channel
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // record builders; fields of the other kind are filled at random since they must not matter
  function automatic record_t rand_record();
    record_t r;
    r.kind       = ($urandom_range(0, 1) == 0) ? KIND_GPS : KIND_ATTITUDE;
    r.latitude   = $urandom;
    r.longitude  = $urandom;
    r.speed      = 16'($urandom);
    r.heading    = 16'($urandom);
    r.altitude   = 16'($urandom);
    r.satellites = 8'($urandom);
    r.pitch      = 16'($urandom);
    r.roll       = 16'($urandom);
    r.yaw        = 16'($urandom);
    // lean on the altitude wrap now and then
    if ($urandom_range(0, 7) == 0) begin
      r.altitude = 16'($urandom_range(64500, 65535));
    end
    return r;
  endfunction

  function automatic record_t mk_gps(input logic [31:0] lat, input logic [31:0] lon,
                                     input logic [15:0] spd, input logic [15:0] hdg,
                                     input logic [15:0] alt, input logic [7:0] sats);
    record_t r;
    r = rand_record();
    r.kind       = KIND_GPS;
    r.latitude   = lat;
    r.longitude  = lon;
    r.speed      = spd;
    r.heading    = hdg;
    r.altitude   = alt;
    r.satellites = sats;
    return r;
  endfunction

  function automatic record_t mk_att(input logic [15:0] p, input logic [15:0] rl,
                                     input logic [15:0] y);
    record_t r;
    r = rand_record();
    r.kind  = KIND_ATTITUDE;
    r.pitch = p;
    r.roll  = rl;
    r.yaw   = y;
    return r;
  endfunction

  task automatic send_batch(input int count);
    repeat (count) queue_record(rand_record());
  endtask

  // idle means nothing queued, nothing offered and no beat still owed
  task automatic wait_drained();
    do @(posedge clk_i);
    while (records_to_send.size() != 0 || in_valid_i || frame_beats_due.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == REG_DEVICE_ADDRESS) begin
      addr_shadow = val;
    end else if (idx == REG_CRC_POLYNOMIAL) begin
      poly_shadow = val;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus sequence, phase by phase
  initial begin
    // reset falls just after time zero so the asynchronous resets see the edge
    #1 rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes at reset register values
    gap_pct   = 25;
    stall_pct = 25;
    queue_record(mk_gps(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00));
    queue_record(mk_gps(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 8'hFF));
    queue_record(mk_gps(32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h0001,
                        16'd64536, 8'h80));  // altitude wraps to zero
    queue_record(mk_gps(32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h8000,
                        16'd64535, 8'h01));  // last value before the wrap
    queue_record(mk_gps(32'h00000001, 32'hFFFFFFFE, 16'h00FF, 16'hFF00,
                        16'd65000, 8'h7F));
    queue_record(mk_att(16'h0000, 16'h0000, 16'h0000));
    queue_record(mk_att(16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_record(mk_att(16'h8000, 16'h7FFF, 16'h0000));
    queue_record(mk_att(16'h7FFF, 16'h8000, 16'hFFFF));
    queue_record(mk_att(16'h0001, 16'hFFFE, 16'h8000));
    // alternating kinds back to back
    queue_record(mk_gps($urandom, $urandom, 16'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom)));
    queue_record(mk_att(16'($urandom), 16'($urandom), 16'($urandom)));
    queue_record(mk_gps($urandom, $urandom, 16'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom)));
    queue_record(mk_att(16'($urandom), 16'($urandom), 16'($urandom)));
    queue_record(mk_gps(32'h0, 32'h0, 16'h0, 16'h0, 16'd64536, 8'h00));
    queue_record(mk_att(16'h8000, 16'h8000, 16'h8000));
    wait_drained();

    // all-zero registers
    write_reg(REG_DEVICE_ADDRESS, 8'h00);
    write_reg(REG_CRC_POLYNOMIAL, 8'h00);
    send_batch(40);
    wait_drained();

    // all-ones registers
    write_reg(REG_DEVICE_ADDRESS, 8'hFF);
    write_reg(REG_CRC_POLYNOMIAL, 8'hFF);
    send_batch(40);
    wait_drained();

    // spare indexes must leave both registers alone
    write_reg(REG_SPARE_LO, 8'($urandom));
    write_reg(REG_SPARE_HI, 8'($urandom));
    send_batch(10);
    wait_drained();

    // random registers; sender never idles while the receiver holds off
    write_reg(REG_DEVICE_ADDRESS, 8'($urandom));
    write_reg(REG_CRC_POLYNOMIAL, 8'($urandom));
    gap_pct = 0;
    send_batch(50);
    hold_requests = hold_requests + 1;
    wait_drained();

    // a stretch with no idling at all
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_CRC_POLYNOMIAL, 8'($urandom));
    send_batch(60);
    wait_drained();

    // back to the reset values, idling again, then a clean run to the end
    write_reg(REG_DEVICE_ADDRESS, DEVICE_ADDRESS_RST);
    write_reg(REG_CRC_POLYNOMIAL, CRC_POLYNOMIAL_RST);
    gap_pct   = 30;
    stall_pct = 30;
    send_batch(60);
    wait_drained();
    gap_pct   = 0;
    stall_pct = 0;
    send_batch(50);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[crsf_telemetry_frame_builder.f]
rtl/core/crsf_pkg.sv
rtl/core/crsf_front.sv
rtl/core/crsf_queue.sv
rtl/core/crsf_back.sv
rtl/core/crsf_telemetry_frame_builder.sv
rtl/core/crsf_chk.sv
dv/tb_top.sv
